@@ hdl/fmqd_pkg.sv @@
// fmqd_pkg: shared constants, types and coefficient tables of the fm demodulator
// no dependencies
`default_nettype none
package fmqd_pkg;
    localparam int TAPS = 64;
    localparam int TAP_W = $clog2(TAPS);
    localparam int BLOCK_LEN = 1000;
    localparam int FIRST_DECIM = 10;
    localparam int SECOND_DECIM = 5;
    localparam int N_DEC = BLOCK_LEN / FIRST_DECIM;
    localparam int N_OUT = N_DEC / SECOND_DECIM;
    localparam int POS_W = $clog2(BLOCK_LEN);
    localparam int PH1_W = $clog2(FIRST_DECIM + 1);
    localparam int DEC_W = $clog2(N_DEC + 1);
    localparam int PH2_W = $clog2(SECOND_DECIM + 1);
    localparam int OUT_W = $clog2(N_OUT + 1);
    localparam int SAMPLE_WIDTH = 16;
    localparam int COEF_W = 18;
    localparam int COEF_FRAC = 17;
    localparam int DISC_FRAC = 12;
    localparam int ACC_W = SAMPLE_WIDTH + COEF_W + TAP_W + 1;
    localparam int NUM_W = 2 * SAMPLE_WIDTH + 3;
    localparam int DEN_W = 2 * SAMPLE_WIDTH + 1;
    localparam int QUO_W = 41;
    localparam int QDEPTH = 2;

    typedef logic signed [SAMPLE_WIDTH-1:0] t_sample;
    typedef logic signed [COEF_W-1:0] t_coef;

    // one decimated job from front to back
    typedef struct packed {
        t_sample fi;
        t_sample fq;
        logic    first;
        logic    emit;
        logic    last;
    } t_job;

    function automatic t_coef channel_coef(input logic [TAP_W-1:0] idx);
        t_coef c;
        case (idx)
            6'd0, 6'd63: c = -18'sd75;      6'd1, 6'd62: c = -18'sd29;
            6'd2, 6'd61: c = 18'sd33;       6'd3, 6'd60: c = 18'sd104;
            6'd4, 6'd59: c = 18'sd170;      6'd5, 6'd58: c = 18'sd207;
            6'd6, 6'd57: c = 18'sd185;      6'd7, 6'd56: c = 18'sd83;
            6'd8, 6'd55: c = -18'sd100;     6'd9, 6'd54: c = -18'sd332;
            6'd10, 6'd53: c = -18'sd544;    6'd11, 6'd52: c = -18'sd648;
            6'd12, 6'd51: c = -18'sd562;    6'd13, 6'd50: c = -18'sd242;
            6'd14, 6'd49: c = 18'sd284;     6'd15, 6'd48: c = 18'sd903;
            6'd16, 6'd47: c = 18'sd1432;    6'd17, 6'd46: c = 18'sd1658;
            6'd18, 6'd45: c = 18'sd1402;    6'd19, 6'd44: c = 18'sd592;
            6'd20, 6'd43: c = -18'sd684;    6'd21, 6'd42: c = -18'sd2161;
            6'd22, 6'd41: c = -18'sd3426;   6'd23, 6'd40: c = -18'sd3999;
            6'd24, 6'd39: c = -18'sd3447;   6'd25, 6'd38: c = -18'sd1505;
            6'd26, 6'd37: c = 18'sd1829;    6'd27, 6'd36: c = 18'sd6250;
            6'd28, 6'd35: c = 18'sd11182;   6'd29, 6'd34: c = 18'sd15872;
            6'd30, 6'd33: c = 18'sd19544;   6'd31, 6'd32: c = 18'sd21560;
            default: c = '0;
        endcase
        return c;
    endfunction

    function automatic t_coef audio_coef(input logic [TAP_W-1:0] idx);
        t_coef c;
        case (idx)
            6'd0, 6'd63: c = -18'sd48;      6'd1, 6'd62: c = -18'sd18;
            6'd2, 6'd61: c = 18'sd20;       6'd3, 6'd60: c = 18'sd67;
            6'd4, 6'd59: c = 18'sd124;      6'd5, 6'd58: c = 18'sd191;
            6'd6, 6'd57: c = 18'sd258;      6'd7, 6'd56: c = 18'sd315;
            6'd8, 6'd55: c = 18'sd346;      6'd9, 6'd54: c = 18'sd332;
            6'd10, 6'd53: c = 18'sd256;     6'd11, 6'd52: c = 18'sd105;
            6'd12, 6'd51: c = -18'sd124;    6'd13, 6'd50: c = -18'sd425;
            6'd14, 6'd49: c = -18'sd775;    6'd15, 6'd48: c = -18'sd1138;
            6'd16, 6'd47: c = -18'sd1464;   6'd17, 6'd46: c = -18'sd1695;
            6'd18, 6'd45: c = -18'sd1767;   6'd19, 6'd44: c = -18'sd1618;
            6'd20, 6'd43: c = -18'sd1199;   6'd21, 6'd42: c = -18'sd478;
            6'd22, 6'd41: c = 18'sd555;     6'd23, 6'd40: c = 18'sd1879;
            6'd24, 6'd39: c = 18'sd3446;    6'd25, 6'd38: c = 18'sd5179;
            6'd26, 6'd37: c = 18'sd6978;    6'd27, 6'd36: c = 18'sd8729;
            6'd28, 6'd35: c = 18'sd10313;   6'd29, 6'd34: c = 18'sd11618;
            6'd30, 6'd33: c = 18'sd12546;   6'd31, 6'd32: c = 18'sd13029;
            default: c = '0;
        endcase
        return c;
    endfunction

    // round half up by COEF_FRAC and saturate to a sample
    function automatic t_sample round_sat(input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W-1:0] r;
        r = (acc + (ACC_W)'(1 << (COEF_FRAC - 1))) >>> COEF_FRAC;
        if (r > (ACC_W)'(32767)) return 16'sh7fff;
        if (r < -(ACC_W)'(32768)) return 16'sh8000;
        return r[SAMPLE_WIDTH-1:0];
    endfunction
endpackage
`default_nettype wire

@@ hdl/fm_quadrature_demodulator.sv @@
// fm_quadrature_demodulator: top level, front, job queue and back
// depends on fmqd_pkg, fmqd_front, fmqd_queue, fmqd_back
`default_nettype none
// Each I/Q transaction runs the channel filter mac in the front, which walks 64
// taps one per cycle with both channels in parallel; the front takes no new sample
// until it is done, and a transaction that queues a decimated value also waits
// while the queue is full. Every 10th sample in a 1000-sample block is queued for
// the back, which runs the discriminator bit-serial divide plus the 64-tap audio
// mac and holds a finished result in its output register, stalling only when the
// next result is ready before that one has left; one result leaves for every 5
// queued values, last marking the final one of a block.
module fm_quadrature_demodulator (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [15:0] i_i_sample,
    input  wire logic [15:0] i_q_sample,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [15:0]      o_demod_value,
    output logic             o_last
);
    fmqd_pkg::t_job w_fjob, w_bjob;
    logic w_fv, w_fr, w_bv, w_br;
    fmqd_pkg::t_sample w_val;

    fmqd_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready,
        .i_i(fmqd_pkg::t_sample'(i_i_sample)), .i_q(fmqd_pkg::t_sample'(i_q_sample)),
        .o_job_valid(w_fv), .i_job_ready(w_fr), .o_job(w_fjob)
    );
    fmqd_queue u_queue (
        .i_clk, .i_rst_n, .i_valid(w_fv), .o_ready(w_fr), .i_job(w_fjob),
        .o_valid(w_bv), .i_ready(w_br), .o_job(w_bjob)
    );
    fmqd_back u_back (
        .i_clk, .i_rst_n, .i_valid(w_bv), .o_ready(w_br), .i_job(w_bjob),
        .o_valid, .i_ready, .o_value(w_val), .o_last
    );
    assign o_demod_value = w_val;
endmodule
`default_nettype wire

@@ hdl/fmqd_front.sv @@
// fmqd_front: channel fir on i and q, block position tracking, decimation
// depends on fmqd_pkg
`default_nettype none
module fmqd_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire fmqd_pkg::t_sample i_i,
    input  wire fmqd_pkg::t_sample i_q,
    output logic                   o_job_valid,
    input  wire logic              i_job_ready,
    output fmqd_pkg::t_job         o_job
);
    typedef enum logic [2:0] {S_IDLE, S_MAC, S_DRAIN, S_DONE, S_PUSH} t_state;

    t_state r_state;
    fmqd_pkg::t_sample r_iline [fmqd_pkg::TAPS];
    fmqd_pkg::t_sample r_qline [fmqd_pkg::TAPS];
    fmqd_pkg::t_sample r_rd_i, r_rd_q;
    logic [fmqd_pkg::TAP_W-1:0] r_wp, r_ra, r_rtap;
    logic [fmqd_pkg::TAP_W:0] r_fill;
    logic r_rv, r_rz;
    logic [fmqd_pkg::TAP_W-1:0] r_tap;
    logic signed [fmqd_pkg::ACC_W-1:0] r_acc_i, r_acc_q;
    logic signed [fmqd_pkg::ACC_W-1:0] r_pi, r_pq;
    logic r_pvalid;
    logic [fmqd_pkg::PH1_W-1:0] r_ph1;
    logic [fmqd_pkg::DEC_W-1:0] r_dec;
    logic [fmqd_pkg::PH2_W-1:0] r_ph2;
    logic [fmqd_pkg::OUT_W-1:0] r_outn;
    logic [fmqd_pkg::POS_W-1:0] r_pos;
    logic r_take;
    fmqd_pkg::t_job r_job;
    fmqd_pkg::t_coef w_c;
    fmqd_pkg::t_sample w_xi, w_xq;

    assign o_ready = (r_state == S_IDLE);
    assign o_job_valid = (r_state == S_PUSH);
    assign o_job = r_job;
    assign w_c = fmqd_pkg::channel_coef(r_rtap);
    // taps not yet filled since reset read as zero
    assign w_xi = r_rz ? fmqd_pkg::t_sample'(0) : r_rd_i;
    assign w_xq = r_rz ? fmqd_pkg::t_sample'(0) : r_rd_q;

    // circular delay lines, written on each accepted transaction, registered read
    always_ff @(posedge i_clk) begin
        if (i_rst_n && i_valid && o_ready) begin
            r_iline[r_wp] <= i_i;
            r_qline[r_wp] <= i_q;
        end
        r_rd_i <= r_iline[r_ra];
        r_rd_q <= r_qline[r_ra];
    end

    // sequencer: one shared mac per channel, one tap per cycle, read and product registered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pos <= '0; r_ph1 <= '0; r_dec <= '0; r_ph2 <= '0; r_outn <= '0;
            r_pvalid <= 1'b0; r_tap <= '0; r_take <= 1'b0;
            r_wp <= '0; r_ra <= '0; r_fill <= '0; r_rv <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_take <= (r_ph1 == '0) && (r_dec < fmqd_pkg::DEC_W'(fmqd_pkg::N_DEC));
                        r_job.first <= (r_dec == '0);
                        r_job.emit <= (r_ph2 == '0)
                            && (r_outn < fmqd_pkg::OUT_W'(fmqd_pkg::N_OUT));
                        r_job.last <= (r_outn == fmqd_pkg::OUT_W'(fmqd_pkg::N_OUT - 1));
                        if (r_ph1 == '0 && r_dec < fmqd_pkg::DEC_W'(fmqd_pkg::N_DEC)) begin
                            r_dec <= r_dec + 1'b1;
                            if (r_ph2 == fmqd_pkg::PH2_W'(fmqd_pkg::SECOND_DECIM - 1)) begin
                                r_ph2 <= '0;
                            end else begin
                                r_ph2 <= r_ph2 + 1'b1;
                            end
                            if (r_ph2 == '0) r_outn <= r_outn + 1'b1;
                        end
                        r_ph1 <= (r_ph1 == fmqd_pkg::PH1_W'(fmqd_pkg::FIRST_DECIM - 1))
                            ? '0 : r_ph1 + 1'b1;
                        if (r_pos == fmqd_pkg::POS_W'(fmqd_pkg::BLOCK_LEN - 1)) begin
                            r_pos <= '0; r_ph1 <= '0; r_dec <= '0; r_ph2 <= '0;
                            r_outn <= '0;
                        end else begin
                            r_pos <= r_pos + 1'b1;
                        end
                        // newest sample sits at the write pointer
                        r_ra <= r_wp;
                        r_wp <= r_wp + 1'b1;
                        if (r_fill != (fmqd_pkg::TAP_W+1)'(fmqd_pkg::TAPS)) begin
                            r_fill <= r_fill + 1'b1;
                        end
                        r_tap <= '0; r_rv <= 1'b0; r_pvalid <= 1'b0;
                        r_acc_i <= '0; r_acc_q <= '0;
                        r_state <= S_MAC;
                    end
                end
                S_MAC: begin
                    r_ra <= r_ra - 1'b1;
                    r_rtap <= r_tap;
                    r_rz <= ({1'b0, r_tap} >= r_fill);
                    r_rv <= 1'b1;
                    if (r_rv) begin
                        r_pi <= (fmqd_pkg::ACC_W)'(w_xi * w_c);
                        r_pq <= (fmqd_pkg::ACC_W)'(w_xq * w_c);
                    end
                    r_pvalid <= r_rv;
                    if (r_pvalid) begin
                        r_acc_i <= r_acc_i + r_pi;
                        r_acc_q <= r_acc_q + r_pq;
                    end
                    r_tap <= r_tap + 1'b1;
                    if (r_tap == fmqd_pkg::TAP_W'(fmqd_pkg::TAPS - 1)) r_state <= S_DRAIN;
                end
                S_DRAIN: begin
                    r_pi <= (fmqd_pkg::ACC_W)'(w_xi * w_c);
                    r_pq <= (fmqd_pkg::ACC_W)'(w_xq * w_c);
                    r_acc_i <= r_acc_i + r_pi;
                    r_acc_q <= r_acc_q + r_pq;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    r_job.fi <= fmqd_pkg::round_sat(r_acc_i + r_pi);
                    r_job.fq <= fmqd_pkg::round_sat(r_acc_q + r_pq);
                    r_state <= r_take ? S_PUSH : S_IDLE;
                end
                S_PUSH: begin
                    if (i_job_ready) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

@@ hdl/fmqd_queue.sv @@
// fmqd_queue: short fifo of decimated jobs between front and back
// depends on fmqd_pkg
`default_nettype none
module fmqd_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  wire fmqd_pkg::t_job i_job,
    output logic                o_valid,
    input  wire logic           i_ready,
    output fmqd_pkg::t_job      o_job
);
    localparam int AW = $clog2(fmqd_pkg::QDEPTH);
    fmqd_pkg::t_job r_mem [fmqd_pkg::QDEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0] r_cnt;
    logic w_push, w_pop;

    assign o_ready = (r_cnt != (AW+1)'(fmqd_pkg::QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job = r_mem[r_rp];
    assign w_push = i_valid && o_ready;
    assign w_pop = o_valid && i_ready;

    // storage and pointers
    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wp] <= i_job;
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (w_push) r_wp <= r_wp + 1'b1;
            if (w_pop) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(w_push) - (AW+1)'(w_pop);
        end
    end
endmodule
`default_nettype wire

@@ hdl/fmqd_back.sv @@
// fmqd_back: discriminator with serial divider, audio fir, output register
// depends on fmqd_pkg
`default_nettype none
module fmqd_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire fmqd_pkg::t_job    i_job,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output fmqd_pkg::t_sample      o_value,
    output logic                   o_last
);
    typedef enum logic [2:0] {
        S_IDLE, S_MUL, S_SUM, S_DIV, S_FIX, S_MAC, S_DRAIN, S_DONE
    } t_state;
    localparam int DIVW = fmqd_pkg::NUM_W + fmqd_pkg::DISC_FRAC + 1;
    localparam int DCW = $clog2(DIVW + 1);

    t_state r_state;
    fmqd_pkg::t_sample r_aline [fmqd_pkg::TAPS];
    fmqd_pkg::t_sample r_ard;
    logic [fmqd_pkg::TAP_W-1:0] r_awp, r_ara, r_rtap;
    logic [fmqd_pkg::TAP_W:0] r_afill;
    logic r_rv, r_rz;
    fmqd_pkg::t_sample r_pi, r_pqv, r_ci, r_cq;
    logic r_emit, r_last;
    logic signed [fmqd_pkg::SAMPLE_WIDTH:0] r_di, r_dq;
    logic signed [fmqd_pkg::NUM_W-1:0] r_m1, r_m2, r_m3, r_m4;
    logic [fmqd_pkg::DEN_W:0] r_den2;
    logic [DIVW-1:0] r_dvd;
    logic [DIVW:0] r_rem;
    logic [DIVW-1:0] r_quo;
    logic [DCW-1:0] r_cnt;
    logic r_neg, r_zero;
    fmqd_pkg::t_sample w_disc;
    logic [fmqd_pkg::TAP_W-1:0] r_tap;
    logic signed [fmqd_pkg::ACC_W-1:0] r_acc, r_p;
    logic r_pv;
    fmqd_pkg::t_coef w_c;
    fmqd_pkg::t_sample w_x;
    logic [DIVW:0] w_sh;

    assign o_ready = (r_state == S_IDLE);
    assign w_c = fmqd_pkg::audio_coef(r_rtap);
    // taps not yet filled since reset read as zero
    assign w_x = r_rz ? fmqd_pkg::t_sample'(0) : r_ard;
    assign w_sh = {r_rem[DIVW-1:0], r_dvd[DIVW-1]};

    // circular audio delay line takes the discriminator output when the mac starts
    always_ff @(posedge i_clk) begin
        if (i_rst_n && r_state == S_FIX) r_aline[r_awp] <= w_disc;
        r_ard <= r_aline[r_ara];
    end

    // discriminator and audio fir sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; o_valid <= 1'b0;
            r_pi <= '0; r_pqv <= '0;
            r_awp <= '0; r_ara <= '0; r_afill <= '0; r_rv <= 1'b0;
        end else begin
            // output register: a new result loads once the previous one has left
            if (r_state == S_DONE && r_emit && (!o_valid || i_ready)) begin
                o_valid <= 1'b1;
                o_value <= fmqd_pkg::round_sat(r_acc + r_p);
                o_last <= r_last;
            end else if (i_ready) begin
                o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_ci <= i_job.fi; r_cq <= i_job.fq;
                        r_emit <= i_job.emit; r_last <= i_job.last;
                        r_di <= (fmqd_pkg::SAMPLE_WIDTH+1)'(i_job.fi)
                            - (i_job.first ? '0 : (fmqd_pkg::SAMPLE_WIDTH+1)'(r_pi));
                        r_dq <= (fmqd_pkg::SAMPLE_WIDTH+1)'(i_job.fq)
                            - (i_job.first ? '0 : (fmqd_pkg::SAMPLE_WIDTH+1)'(r_pqv));
                        r_pi <= i_job.fi; r_pqv <= i_job.fq;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_m1 <= (fmqd_pkg::NUM_W)'(r_ci * r_dq);
                    r_m2 <= (fmqd_pkg::NUM_W)'(r_cq * r_di);
                    r_m3 <= (fmqd_pkg::NUM_W)'(r_ci * r_ci);
                    r_m4 <= (fmqd_pkg::NUM_W)'(r_cq * r_cq);
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_neg <= (r_m1 < r_m2);
                    r_den2 <= {r_m3[fmqd_pkg::DEN_W-1:0] + r_m4[fmqd_pkg::DEN_W-1:0], 1'b0};
                    r_zero <= (r_m3 == '0) && (r_m4 == '0);
                    r_dvd <= (r_m1 < r_m2)
                        ? (DIVW)'({r_m2 - r_m1, 1'b0}) << fmqd_pkg::DISC_FRAC
                        : (DIVW)'({r_m1 - r_m2, 1'b0}) << fmqd_pkg::DISC_FRAC;
                    r_rem <= '0; r_quo <= '0; r_cnt <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    // restoring divide of (2|num|*2^12 + den) by 2den, one bit a cycle
                    if (r_cnt == '0 && r_quo == '0 && r_rem == '0) begin
                        r_dvd <= r_dvd + (DIVW)'(r_den2 >> 1);
                        r_cnt <= DCW'(1);
                    end else begin
                        r_dvd <= r_dvd << 1;
                        if (w_sh >= (DIVW+1)'(r_den2)) begin
                            r_rem <= w_sh - (DIVW+1)'(r_den2);
                            r_quo <= {r_quo[DIVW-2:0], 1'b1};
                        end else begin
                            r_rem <= w_sh;
                            r_quo <= {r_quo[DIVW-2:0], 1'b0};
                        end
                        r_cnt <= r_cnt + 1'b1;
                        if (r_cnt == DCW'(DIVW)) r_state <= S_FIX;
                    end
                end
                S_FIX: begin
                    // newest audio value sits at the write pointer
                    r_ara <= r_awp;
                    r_awp <= r_awp + 1'b1;
                    if (r_afill != (fmqd_pkg::TAP_W+1)'(fmqd_pkg::TAPS)) begin
                        r_afill <= r_afill + 1'b1;
                    end
                    r_tap <= '0; r_rv <= 1'b0; r_pv <= 1'b0; r_acc <= '0;
                    r_state <= S_MAC;
                end
                S_MAC: begin
                    r_ara <= r_ara - 1'b1;
                    r_rtap <= r_tap;
                    r_rz <= ({1'b0, r_tap} >= r_afill);
                    r_rv <= 1'b1;
                    if (r_rv) r_p <= (fmqd_pkg::ACC_W)'(w_x * w_c);
                    r_pv <= r_rv;
                    if (r_pv) r_acc <= r_acc + r_p;
                    r_tap <= r_tap + 1'b1;
                    if (r_tap == fmqd_pkg::TAP_W'(fmqd_pkg::TAPS - 1)) r_state <= S_DRAIN;
                end
                S_DRAIN: begin
                    r_p <= (fmqd_pkg::ACC_W)'(w_x * w_c);
                    r_acc <= r_acc + r_p;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    // wait here only while an earlier result still occupies the output
                    if (!r_emit || !o_valid || i_ready) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // saturate the quotient to a q3.12 value
    always_comb begin
        if (r_zero) begin
            w_disc = '0;
        end else if (r_neg) begin
            w_disc = (r_quo > (DIVW)'(32768)) ? 16'sh8000 : -r_quo[15:0];
        end else begin
            w_disc = (r_quo > (DIVW)'(32767)) ? 16'sh7fff : r_quo[15:0];
        end
    end
endmodule
`default_nettype wire

@@ hdl/fmqd_checker.sv @@
// fmqd_checker: port-level assertions for the demodulator, bound to the top
// depends on fm_quadrature_demodulator
`default_nettype none
module fmqd_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        o_ready,
    input wire logic        o_valid,
    input wire logic        i_ready,
    input wire logic [15:0] o_demod_value,
    input wire logic        o_last
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_demod_value) && $stable(o_last))
        else $error("result changed while stalled");
    a_no_out_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid) else $error("result right after reset");
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready) else $error("ready after accept");
endmodule
bind fm_quadrature_demodulator fmqd_checker u_chk (.*);
`default_nettype wire
